// ===== src/ctbk_pkg.sv =====
// shared types and constants for the countdown timer bank
// command codes, controller states, controller/datapath command and status structs
package ctbk_pkg;

	localparam int NUM_TIMERS_DEF      = 256;
	localparam int RESERVED_TIMERS_DEF = 12;

	localparam int CMD_W     = 3;
	localparam int INDEX_W   = 8;
	localparam int VALUE_W   = 32;
	localparam int ELAPSED_W = 16;

	typedef enum logic [CMD_W-1:0] {
		CMD_NEW   = 3'd0,
		CMD_GET   = 3'd1,
		CMD_ADD   = 3'd2,
		CMD_CLEAR = 3'd3,
		CMD_STOP  = 3'd4,
		CMD_START = 3'd5,
		CMD_TICK  = 3'd6
	} cmd_e_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_WAIT,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;   // take the input beat
		logic clr_wr;    // clearing pass write at the pointer
		logic ptr_inc;
		logic rd_ptr;    // read entry at the pointer
		logic rd_idx;    // read entry addressed by the command
		logic proc;      // act on the entry read last cycle
		logic set_flag;  // apply stop or start
		logic out_load;  // move result into the output register
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		cmd_e_t cmd;
		logic   idx_ok;
		logic   tick_skip;
		logic   ptr_last;
		logic   s1_vld;
		logic   hit;     // free entry found during an allocation scan
	} dp_stat_t;

endpackage

// ===== src/ctbk_dp.sv =====
// datapath of the countdown timer bank: timer memory, scan pointer, entry update
// depends on ctbk_pkg; driven by ctbk_ctrl
module ctbk_dp #(
	parameter int NUM_TIMERS      = ctbk_pkg::NUM_TIMERS_DEF,
	parameter int RESERVED_TIMERS = ctbk_pkg::RESERVED_TIMERS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  ctbk_pkg::ctl_cmd_t                    ctl,
	output ctbk_pkg::dp_stat_t                    st,
	input  logic [ctbk_pkg::CMD_W-1:0]            cmd,
	input  logic [ctbk_pkg::INDEX_W-1:0]          timer_index,
	input  logic signed [ctbk_pkg::VALUE_W-1:0]   amount,
	input  logic [ctbk_pkg::ELAPSED_W-1:0]        elapsed_ms,
	output logic signed [ctbk_pkg::VALUE_W-1:0]   result_value
);
	import ctbk_pkg::*;

	localparam int IW = $clog2(NUM_TIMERS);
	localparam int WW = VALUE_W + 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(NUM_TIMERS - 1);
	localparam logic [IW-1:0] RES_IDX  = IW'(RESERVED_TIMERS);
	localparam logic [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

	// word layout: active bit on top of the signed count
	logic [WW-1:0]          mem_q [NUM_TIMERS];

	cmd_e_t                 cmd_q;
	logic [INDEX_W-1:0]     idx_q;
	logic [VALUE_W-1:0]     amount_q;
	logic [ELAPSED_W-1:0]   elapsed_q;
	logic                   stopped_q;
	logic [IW-1:0]          ptr_q;
	logic                   vld_s1;
	logic [IW-1:0]          addr_s1;
	logic [WW-1:0]          word_s1;
	logic [VALUE_W-1:0]     res_q;
	logic [VALUE_W-1:0]     result_value_q;

	logic [IW+INDEX_W-1:0]  idx_wide;
	logic [IW-1:0]          idx_addr;
	logic                   rd_en;
	logic [IW-1:0]          rd_addr;
	logic                   we;
	logic [IW-1:0]          waddr;
	logic [WW-1:0]          wdata;
	logic [VALUE_W-1:0]     res_nxt;
	logic                   act;
	logic [VALUE_W-1:0]     cnt;
	logic [VALUE_W:0]       tick_diff;
	logic [VALUE_W-1:0]     tick_val;
	logic [VALUE_W:0]       add_sum;
	logic [VALUE_W-1:0]     add_sat;
	logic                   amt_pos;

	// item capture
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q     <= cmd_e_t'(cmd);
			idx_q     <= timer_index;
			amount_q  <= amount;
			elapsed_q <= elapsed_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stopped_q <= 1'b0;
			ptr_q     <= '0;
			vld_s1    <= 1'b0;
		end else begin
			if (ctl.set_flag)
				stopped_q <= (cmd_q == CMD_STOP);
			if (ctl.capture)
				ptr_q <= RES_IDX;
			else if (ctl.ptr_inc)
				ptr_q <= ptr_q + 1'b1;
			vld_s1 <= rd_en;
		end
	end

	assign idx_wide = {{IW{1'b0}}, idx_q};
	assign idx_addr = idx_wide[IW-1:0];
	assign rd_en    = ctl.rd_ptr | ctl.rd_idx;
	assign rd_addr  = ctl.rd_idx ? idx_addr : ptr_q;

	// timer memory, one write and one read port, registered read
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			word_s1 <= mem_q[rd_addr];
			addr_s1 <= rd_addr;
		end
	end

	// entry arithmetic
	assign act       = word_s1[WW-1];
	assign cnt       = word_s1[VALUE_W-1:0];
	assign tick_diff = {cnt[VALUE_W-1], cnt} - {{(VALUE_W+1-ELAPSED_W){1'b0}}, elapsed_q};
	assign tick_val  = (tick_diff[VALUE_W] || tick_diff == '0) ? '0 : tick_diff[VALUE_W-1:0];
	assign add_sum   = {cnt[VALUE_W-1], cnt} + {amount_q[VALUE_W-1], amount_q};
	assign add_sat   = (add_sum[VALUE_W] == add_sum[VALUE_W-1]) ? add_sum[VALUE_W-1:0] :
	                   (add_sum[VALUE_W] ? VAL_MIN : VAL_MAX);
	assign amt_pos   = !amount_q[VALUE_W-1] && (amount_q != '0);

	always_comb begin
		we      = 1'b0;
		waddr   = addr_s1;
		wdata   = '0;
		res_nxt = res_q;
		if (ctl.clr_wr) begin
			we    = 1'b1;
			waddr = ptr_q;
		end else if (ctl.proc) begin
			case (cmd_q)
				CMD_NEW: begin
					if (!act) begin
						we      = 1'b1;
						wdata   = {1'b1, amount_q};
						res_nxt = {{(VALUE_W-IW){1'b0}}, addr_s1};
					end
				end
				CMD_GET: begin
					if (cnt != '0) begin
						res_nxt = cnt;
					end else begin
						we    = 1'b1;
						wdata = amt_pos ? {1'b1, amount_q} : '0;
					end
				end
				CMD_ADD: begin
					we      = 1'b1;
					wdata   = {act, add_sat};
					res_nxt = add_sat;
				end
				CMD_CLEAR: begin
					we = 1'b1;
				end
				CMD_TICK: begin
					if (act) begin
						we    = 1'b1;
						wdata = {1'b1, tick_val};
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture)
			res_q <= '0;
		else
			res_q <= res_nxt;
		if (ctl.out_load)
			result_value_q <= res_q;
	end

	assign result_value = result_value_q;

	assign st.cmd       = cmd_q;
	assign st.idx_ok    = idx_wide < (IW+INDEX_W)'(NUM_TIMERS);
	assign st.tick_skip = stopped_q || (elapsed_q == '0);
	assign st.ptr_last  = (ptr_q == LAST_IDX);
	assign st.s1_vld    = vld_s1;
	assign st.hit       = vld_s1 && (cmd_q == CMD_NEW) && !act;

endmodule

// ===== src/ctbk_ctrl.sv =====
// controller of the countdown timer bank: sequencing state machine and output valid
// depends on ctbk_pkg; commands ctbk_dp
module ctbk_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	input  ctbk_pkg::dp_stat_t st,
	output ctbk_pkg::ctl_cmd_t ctl
);
	import ctbk_pkg::*;

	state_t state_q, state_nxt;
	logic   out_valid_q;
	logic   accept;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (ctl.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_nxt = state_q;
		ctl       = '0;
		case (state_q)
			ST_CLEAR: begin
				ctl.clr_wr  = 1'b1;
				ctl.ptr_inc = !st.ptr_last;
				if (st.ptr_last)
					state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					ctl.capture = 1'b1;
					state_nxt   = ST_DECODE;
				end
			end
			ST_DECODE: begin
				case (st.cmd)
					CMD_NEW: state_nxt = ST_SCAN;
					CMD_GET, CMD_ADD, CMD_CLEAR: begin
						if (st.idx_ok) begin
							ctl.rd_idx = 1'b1;
							state_nxt  = ST_WAIT;
						end else begin
							state_nxt = ST_FINISH;
						end
					end
					CMD_TICK: state_nxt = st.tick_skip ? ST_FINISH : ST_SCAN;
					CMD_STOP, CMD_START: begin
						ctl.set_flag = 1'b1;
						state_nxt    = ST_FINISH;
					end
					default: state_nxt = ST_FINISH;
				endcase
			end
			ST_WAIT: begin
				ctl.proc  = 1'b1;
				state_nxt = ST_FINISH;
			end
			ST_SCAN: begin
				// read entry i+1 while entry i is updated
				ctl.rd_ptr  = 1'b1;
				ctl.ptr_inc = !st.ptr_last;
				ctl.proc    = st.s1_vld;
				if (st.hit)
					state_nxt = ST_FINISH;
				else if (st.ptr_last)
					state_nxt = ST_DRAIN;
			end
			ST_DRAIN: begin
				ctl.proc  = st.s1_vld;
				state_nxt = ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					ctl.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_DECODE)
		else $error("accepted beat not decoded");

	a_out_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load |-> (!out_valid_q || !out_stall))
		else $error("result overwrote a waiting beat");

	a_hit_ends_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(st.hit && (state_q == ST_SCAN || state_q == ST_DRAIN)) |=> state_q == ST_FINISH)
		else $error("allocation scan ran past a free timer");

	a_s1_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		st.s1_vld |-> ($past(state_q) == ST_DECODE || $past(state_q) == ST_SCAN))
		else $error("read stage valid without a read");

endmodule

// ===== src/countdown_timer_bank_top.sv =====
// top level of the countdown timer bank: one beat in, one result beat out
// new and tick scan timers from RESERVED_TIMERS on; get/add/clear access one timer, others none
// a new beat is taken only back in idle, once the last result is in the output register;
// a scan goes through the single read and write port of the timer memory
// reset: asynchronous; a clearing pass over all NUM_TIMERS entries zeroes the memory, in_stall held high
// depends on ctbk_pkg, ctbk_ctrl, ctbk_dp
module countdown_timer_bank_top #(
	parameter int NUM_TIMERS      = ctbk_pkg::NUM_TIMERS_DEF,
	parameter int RESERVED_TIMERS = ctbk_pkg::RESERVED_TIMERS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// command beat
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [ctbk_pkg::CMD_W-1:0]          cmd,
	input  logic [ctbk_pkg::INDEX_W-1:0]        timer_index,
	input  logic signed [ctbk_pkg::VALUE_W-1:0] amount,
	input  logic [ctbk_pkg::ELAPSED_W-1:0]      elapsed_ms,
	// result beat
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [ctbk_pkg::VALUE_W-1:0] result_value
);
	import ctbk_pkg::*;

	ctl_cmd_t ctl;
	dp_stat_t st;

	// controller: walks clear pass, decode, single access or scan where needed, then result hand-off
	ctbk_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.st        (st),
		.ctl       (ctl)
	);

	// datapath: timer memory with one pipelined read-modify-write per cycle during a scan
	ctbk_dp #(
		.NUM_TIMERS      (NUM_TIMERS),
		.RESERVED_TIMERS (RESERVED_TIMERS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.st           (st),
		.cmd          (cmd),
		.timer_index  (timer_index),
		.amount       (amount),
		.elapsed_ms   (elapsed_ms),
		.result_value (result_value)
	);

endmodule
